/* hw/rtl/assert_macros.svh */
// Assertion macros used by the pfp_checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: label");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: label");

`endif

/* hw/rtl/pfp_pkg.sv */
// ----------------------------------------------------------------------------
// pfp_pkg
// Constants, types and helpers shared by the particle sensor frame parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pfp_pkg;

    localparam logic [7:0] Hdr0 = 8'h42;
    localparam logic [7:0] Hdr1 = 8'h4D;
    localparam logic [7:0] Hdr2 = 8'h00;
    localparam logic [7:0] Hdr3 = 8'h1C;

    // Frame byte positions.
    localparam logic [4:0] PosPayloadFirst = 5'd4;
    localparam logic [4:0] PosPayloadLast  = 5'd27;
    localparam logic [4:0] PosChkHi        = 5'd30;

    localparam int         NumReadings = 12;
    localparam logic [3:0] LastReading = 4'd11;

    localparam int FrameQueueDepth = 2;

    typedef logic [15:0] word_t;

    typedef struct packed {
        logic                         ok;
        word_t [NumReadings-1:0]      words;
    } frame_cmd_t;

    function automatic logic [7:0] header_byte(input logic [1:0] idx);
        logic [7:0] hb;
        unique case (idx)
            2'd0:    hb = Hdr0;
            2'd1:    hb = Hdr1;
            2'd2:    hb = Hdr2;
            default: hb = Hdr3;
        endcase
        return hb;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/pfp_front.sv */
// ----------------------------------------------------------------------------
// pfp_front
// Byte receiver: tracks the header, the running sum and the payload, and
// hands one command per completed frame to the frame queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pfp_front (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [7:0]         s_rx_byte,
    input  wire logic               q_full,
    output logic                    q_push,
    output pfp_pkg::frame_cmd_t     q_push_data
);
    import pfp_pkg::*;

    logic [4:0]               pos_reg, pos_next;
    logic [15:0]              sum_reg, sum_next;
    logic [7:0]               chk_hi_reg, chk_hi_next;
    word_t [NumReadings-1:0]  words_reg, words_next;

    logic       accept;
    logic       last_byte;
    logic [4:0] offset;
    logic [3:0] word_idx;

    // Only the final checksum byte needs room in the queue.
    assign last_byte = (pos_reg == 5'd31);
    assign s_ready   = !last_byte || !q_full;
    assign accept    = s_valid && s_ready;

    assign offset   = pos_reg - PosPayloadFirst;
    assign word_idx = offset[4:1];

    assign q_push_data.ok    = ({chk_hi_reg, s_rx_byte} == sum_reg) && (sum_reg != 16'd0);
    assign q_push_data.words = words_reg;

    always_comb begin
        pos_next    = pos_reg;
        sum_next    = sum_reg;
        chk_hi_next = chk_hi_reg;
        words_next  = words_reg;
        q_push      = 1'b0;
        if (accept) begin
            if (pos_reg < PosPayloadFirst) begin
                if (s_rx_byte == header_byte(pos_reg[1:0])) begin
                    sum_next = sum_reg + {8'd0, s_rx_byte};
                    pos_next = pos_reg + 5'd1;
                end else if (s_rx_byte == Hdr0) begin
                    // A stray first header byte restarts the frame here.
                    sum_next = {8'd0, Hdr0};
                    pos_next = 5'd1;
                end else begin
                    sum_next = 16'd0;
                    pos_next = 5'd0;
                end
            end else if (pos_reg < PosChkHi) begin
                if (pos_reg <= PosPayloadLast) begin
                    if (!offset[0]) begin
                        words_next[word_idx][15:8] = s_rx_byte;
                    end else begin
                        words_next[word_idx][7:0] = s_rx_byte;
                    end
                end
                sum_next = sum_reg + {8'd0, s_rx_byte};
                pos_next = pos_reg + 5'd1;
            end else if (pos_reg == PosChkHi) begin
                chk_hi_next = s_rx_byte;
                pos_next    = pos_reg + 5'd1;
            end else begin
                q_push   = 1'b1;
                sum_next = 16'd0;
                pos_next = 5'd0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= 5'd0;
            sum_reg <= 16'd0;
        end else begin
            pos_reg <= pos_next;
            sum_reg <= sum_next;
        end
    end

    always_ff @(posedge aclk) begin
        chk_hi_reg <= chk_hi_next;
        words_reg  <= words_next;
    end

endmodule

`default_nettype wire

/* hw/rtl/pfp_fifo.sv */
// ----------------------------------------------------------------------------
// pfp_fifo
// Short queue of completed frame commands between receiver and emitter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pfp_fifo (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 push,
    input  wire pfp_pkg::frame_cmd_t  push_data,
    output logic                      full,
    input  wire logic                 pop,
    output pfp_pkg::frame_cmd_t       head,
    output logic                      empty
);
    import pfp_pkg::*;

    localparam int PtrW = (FrameQueueDepth > 1) ? $clog2(FrameQueueDepth) : 1;
    localparam int CntW = $clog2(FrameQueueDepth + 1);
    localparam logic [PtrW-1:0] PtrLast = PtrW'(FrameQueueDepth - 1);
    localparam logic [CntW-1:0] CntFull = CntW'(FrameQueueDepth);

    frame_cmd_t           entry_reg [FrameQueueDepth];
    logic [PtrW-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]      count_reg, count_next;
    logic                 do_push, do_pop;

    assign full    = (count_reg == CntFull);
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PtrLast) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PtrLast) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/pfp_back.sv */
// ----------------------------------------------------------------------------
// pfp_back
// Result emitter: turns the frame command at the queue head into twelve
// readings or one failure result, through a registered output stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pfp_back (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire pfp_pkg::frame_cmd_t  head,
    input  wire logic                 empty,
    output logic                      pop,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic                      m_frame_ok,
    output logic [3:0]                m_reading_index,
    output logic [15:0]               m_reading_value,
    output logic                      m_last_of_frame
);
    import pfp_pkg::*;

    logic        valid_reg, valid_next;
    logic [3:0]  idx_reg, idx_next;
    logic        ok_reg;
    logic [3:0]  index_reg;
    logic [15:0] value_reg;
    logic        last_reg;
    logic        load;
    logic        take;
    logic        head_last;

    // The output stage reloads whenever it is empty or its result transfers.
    assign load      = !valid_reg || m_ready;
    assign take      = load && !empty;
    assign head_last = !head.ok || (idx_reg == LastReading);
    assign pop       = take && head_last;

    always_comb begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (load) begin
            valid_next = !empty;
        end
        if (take) begin
            idx_next = head_last ? 4'd0 : idx_reg + 4'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= 4'd0;
        end else begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            ok_reg    <= head.ok;
            index_reg <= head.ok ? idx_reg : 4'd0;
            value_reg <= head.ok ? head.words[idx_reg] : 16'd0;
            last_reg  <= head_last;
        end
    end

    assign m_valid         = valid_reg;
    assign m_frame_ok      = ok_reg;
    assign m_reading_index = index_reg;
    assign m_reading_value = value_reg;
    assign m_last_of_frame = last_reg;

endmodule

`default_nettype wire

/* hw/rtl/particle_sensor_frame_parser.sv */
// Input: one byte per cycle; s_ready falls only for a final byte while the queue is full.
// Output: results pass the frame queue and output register; one per cycle while m_ready.
// A good frame gives twelve results, a bad one a single result.
// The frame queue holds two completed frames, so readings drain while the next frame arrives.
// Reset (aresetn low, synchronous) clears position, sum, queue pointers and output valid.
// Payload and checksum registers are not reset.
// ----------------------------------------------------------------------------
// particle_sensor_frame_parser
// Checks 32-byte particle sensor frames and emits their readings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module particle_sensor_frame_parser (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_rx_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_frame_ok,
    output logic [3:0]       m_reading_index,
    output logic [15:0]      m_reading_value,
    output logic             m_last_of_frame
);
    import pfp_pkg::*;

    frame_cmd_t push_data;
    frame_cmd_t head;
    logic       push, full, pop, empty;

    pfp_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_rx_byte   (s_rx_byte),
        .q_full      (full),
        .q_push      (push),
        .q_push_data (push_data)
    );

    pfp_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .head      (head),
        .empty     (empty)
    );

    pfp_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .head            (head),
        .empty           (empty),
        .pop             (pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_frame_ok      (m_frame_ok),
        .m_reading_index (m_reading_index),
        .m_reading_value (m_reading_value),
        .m_last_of_frame (m_last_of_frame)
    );

endmodule

`default_nettype wire

/* hw/rtl/pfp_checker.sv */
// ----------------------------------------------------------------------------
// pfp_checker
// Port-level checks on the result channel of the frame parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module pfp_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic        m_frame_ok,
    input wire logic [3:0]  m_reading_index,
    input wire logic [15:0] m_reading_value,
    input wire logic        m_last_of_frame
);
    import pfp_pkg::*;

    // A stalled result stays offered.
    `ASSERT_NEXT(a_hold_valid, aclk, aresetn, m_valid && !m_ready, m_valid)

    // A failure result is a single, zeroed, final transfer.
    `ASSERT_IMPLY(a_fail_shape, aclk, aresetn, m_valid && !m_frame_ok, m_last_of_frame && (m_reading_index == 4'd0) && (m_reading_value == 16'd0))

    // A reading is final exactly when it is the last index.
    `ASSERT_IMPLY(a_ok_last, aclk, aresetn, m_valid && m_frame_ok, m_last_of_frame == (m_reading_index == LastReading))

    // Readings of one frame follow each other without a gap.
    `ASSERT_NEXT(a_ok_next, aclk, aresetn, m_valid && m_ready && m_frame_ok && !m_last_of_frame, m_valid && m_frame_ok && (m_reading_index == $past(m_reading_index) + 4'd1))

endmodule

bind particle_sensor_frame_parser pfp_checker u_pfp_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_frame_ok      (m_frame_ok),
    .m_reading_index (m_reading_index),
    .m_reading_value (m_reading_value),
    .m_last_of_frame (m_last_of_frame)
);

`default_nettype wire

/* bench/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for particle_sensor_frame_parser. Streams header
// noise, broken headers and 32-byte frames with good and bad checksums
// under random sender and receiver idling. A scoreboard tracks the parser
// state byte by byte and checks every reading the block emits.
// ----------------------------------------------------------------------------

module testbench;
    import pfp_pkg::*;

    localparam logic [31:0] HeaderWord = {Hdr0, Hdr1, Hdr2, Hdr3};
    localparam int          WatchdogLimit = 2000;
    localparam int          RandomFrameBytes = 224;
    localparam int          DrainCycles = 20;

    typedef enum int {
        PAY_RANDOM,
        PAY_EXTREME,
        PAY_CORNER
    } payload_mode_t;

    typedef struct packed {
        logic        ok;
        logic [3:0]  index;
        logic [15:0] value;
        logic        last;
    } reading_t;

    class frame_scoreboard;
        logic [4:0]  position;
        logic [15:0] byte_sum;
        logic [7:0]  payload [24];
        logic [7:0]  chk_hi;
        reading_t    expected_q [$];
        int          errors;

        function new();
            position = '0;
            byte_sum = '0;
            chk_hi   = '0;
            errors   = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Advance the tracked parser state by one accepted byte.
        function void note_byte(logic [7:0] b);
            logic [15:0] received;
            reading_t    r;
            if (position < PosPayloadFirst) begin
                if (b == HeaderWord[31 - 8 * position[1:0] -: 8]) begin
                    byte_sum = byte_sum + 16'(b);
                    position = position + 5'd1;
                end else if (b == Hdr0) begin
                    // A stray first header byte restarts the frame.
                    byte_sum = 16'(Hdr0);
                    position = 5'd1;
                end else begin
                    byte_sum = '0;
                    position = '0;
                end
            end else if (position < PosChkHi) begin
                if (position <= PosPayloadLast)
                    payload[position - PosPayloadFirst] = b;
                byte_sum = byte_sum + 16'(b);
                position = position + 5'd1;
            end else if (position == PosChkHi) begin
                chk_hi   = b;
                position = position + 5'd1;
            end else begin
                received = {chk_hi, b};
                if (received == byte_sum && byte_sum != 16'd0) begin
                    for (int i = 0; i < NumReadings; i++) begin
                        r.ok    = 1'b1;
                        r.index = 4'(i);
                        r.value = {payload[2 * i], payload[2 * i + 1]};
                        r.last  = (4'(i) == LastReading);
                        expected_q.push_back(r);
                    end
                end else begin
                    r = '{ok: 1'b0, index: 4'd0, value: 16'd0, last: 1'b1};
                    expected_q.push_back(r);
                end
                position = '0;
                byte_sum = '0;
            end
        endfunction

        function void check_reading(reading_t got);
            reading_t want;
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: ok=%0d index=%0d value=%h last=%0d",
                             got.ok, got.index, got.value, got.last);
                return;
            end
            want = expected_q.pop_front();
            if (got.ok !== want.ok || got.index !== want.index ||
                got.value !== want.value || got.last !== want.last) begin
                errors++;
                if (errors <= 10)
                    $display({"mismatch: expected ok=%0d index=%0d value=%h last=%0d,",
                              " got ok=%0d index=%0d value=%h last=%0d"},
                             want.ok, want.index, want.value, want.last,
                             got.ok, got.index, got.value, got.last);
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_rx_byte = 8'h00;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_frame_ok;
    logic [3:0]  m_reading_index;
    logic [15:0] m_reading_value;
    logic        m_last_of_frame;

    frame_scoreboard sb;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          frame_bytes = 0;

    particle_sensor_frame_parser u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_rx_byte       (s_rx_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_frame_ok      (m_frame_ok),
        .m_reading_index (m_reading_index),
        .m_reading_value (m_reading_value),
        .m_last_of_frame (m_last_of_frame)
    );

    always #1 aclk = ~aclk;

    // Result side: check each transfer and pick the next ready level.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_reading('{ok: m_frame_ok, index: m_reading_index,
                               value: m_reading_value, last: m_last_of_frame});
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WatchdogLimit) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("TEST FAILED");
        $finish;
    end

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        do
            @(posedge aclk);
        while (!s_ready);
        sb.note_byte(b);
    endtask

    // Stop sending until every reading owed so far has been received.
    task automatic wait_for_readings();
        s_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge aclk);
    endtask

    task automatic send_frame(input payload_mode_t mode, input logic [15:0] sum_flip);
        logic [7:0]  fb [32];
        logic [15:0] sum;
        int          k;
        sum = '0;
        for (int i = 0; i < 32; i++) begin
            k = i - 4;
            if (i < 4)
                fb[i] = HeaderWord[31 - 8 * i -: 8];
            else if (mode == PAY_CORNER)
                // Readings cycle through 0xFFFF, 0x0000, 0xFF00 and 0x00FF.
                case ((k / 2) % 4)
                    0:       fb[i] = 8'hFF;
                    1:       fb[i] = 8'h00;
                    2:       fb[i] = (k % 2) ? 8'h00 : 8'hFF;
                    default: fb[i] = (k % 2) ? 8'hFF : 8'h00;
                endcase
            else if (mode == PAY_EXTREME)
                case ($urandom_range(2))
                    0:       fb[i] = 8'h00;
                    1:       fb[i] = 8'hFF;
                    default: fb[i] = 8'($urandom_range(255));
                endcase
            else
                fb[i] = 8'($urandom_range(255));
            if (i < 30)
                sum = sum + 16'(fb[i]);
        end
        sum    = sum ^ sum_flip;
        fb[30] = sum[15:8];
        fb[31] = sum[7:0];
        for (int i = 0; i < 32; i++)
            send_byte(fb[i]);
        frame_bytes += 32;
    endtask

    // Send part of a header and then a byte that does not belong there.
    task automatic send_broken_header();
        int         pos;
        logic [7:0] bad;
        pos = $urandom_range(3);
        for (int i = 0; i < pos; i++)
            send_byte(HeaderWord[31 - 8 * i -: 8]);
        if (pos != 0 && $urandom_range(1) == 0)
            bad = Hdr0;
        else
            do
                bad = 8'($urandom_range(255));
            while (bad == HeaderWord[31 - 8 * pos -: 8]);
        send_byte(bad);
    endtask

    initial begin
        int phase;
        int last_phase;
        int pick;
        int noise_len;
        sb = new();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Header resynchronization cases, then one clean and one corrupt frame.
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(Hdr1);
        send_byte(Hdr0);
        send_byte(Hdr0);
        send_byte(Hdr1);
        send_byte(Hdr0);
        send_byte(Hdr1);
        send_byte(Hdr2);
        send_byte(Hdr0);
        send_byte(Hdr1);
        send_byte(Hdr2);
        send_byte(8'hFF);
        send_frame(PAY_CORNER, 16'h0000);
        send_frame(PAY_RANDOM, 16'hFFFF);
        wait_for_readings();

        frame_bytes = 0;
        last_phase  = 0;
        while (frame_bytes < RandomFrameBytes) begin
            phase = frame_bytes * 4 / RandomFrameBytes;
            if (phase != last_phase) begin
                wait_for_readings();
                last_phase = phase;
            end
            case (phase)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 72; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 72; end
                default: begin send_idle_pct = 33; recv_stall_pct = 33; end
            endcase
            pick = $urandom_range(99);
            if (pick < 55)
                send_frame(PAY_RANDOM, 16'h0000);
            else if (pick < 65)
                send_frame(PAY_EXTREME, 16'h0000);
            else if (pick < 80)
                send_frame(PAY_RANDOM, 16'($urandom_range(65535, 1)));
            else if (pick < 92)
                send_broken_header();
            else begin
                noise_len = $urandom_range(6, 1);
                for (int i = 0; i < noise_len; i++)
                    send_byte(($urandom_range(9) < 3) ? Hdr0 : 8'($urandom_range(255)));
            end
        end

        wait_for_readings();
        repeat (DrainCycles) @(posedge aclk);
        if (sb.pending() != 0) begin
            sb.errors++;
            $display("%0d expected results never arrived", sb.pending());
        end
        if (sb.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

/* particle_sensor_frame_parser.f */
+incdir+hw/rtl
hw/rtl/pfp_pkg.sv
hw/rtl/pfp_front.sv
hw/rtl/pfp_fifo.sv
hw/rtl/pfp_back.sv
hw/rtl/particle_sensor_frame_parser.sv
hw/rtl/pfp_checker.sv
bench/testbench.sv
